@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the register machine executor.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/trmx_pkg.sv @@
// Shared types and constants of the register machine executor.
// No dependencies; imported by every module of the block.
package trmx_pkg;

    // Instruction word layout
    localparam int INSTR_W  = 16;
    localparam int FIELD_W  = 3;
    localparam int IMM_W    = 7;
    localparam int OP_LSB   = 13;
    localparam int DST_LSB  = 10;
    localparam int SRC_LSB  = 7;
    localparam int PRINT_W  = 32;

    typedef logic [FIELD_W-1:0] opcode_t;
    typedef logic [FIELD_W-1:0] reg_idx_t;

    // Opcodes
    localparam opcode_t OPC_ADD   = 3'd0;
    localparam opcode_t OPC_SUB   = 3'd1;
    localparam opcode_t OPC_MUL   = 3'd2;
    localparam opcode_t OPC_DIV   = 3'd3;
    localparam opcode_t OPC_LET   = 3'd4;
    localparam opcode_t OPC_PRINT = 3'd5;

    // Operations of the shared arithmetic unit
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_ADD = 2'd0;
    localparam alu_op_t ALU_SUB = 2'd1;
    localparam alu_op_t ALU_MUL = 2'd2;
    localparam alu_op_t ALU_DIV = 2'd3;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic write_ok;
    } alu_rsp_t;

endpackage

@@ sv/trmx_regfile.sv @@
// Register file of the executor: memory with one write and two registered reads.
// Depends on trmx_pkg; entries not yet written read as zero through valid bits.
module trmx_regfile
    import trmx_pkg::*;
#(
    parameter int REG_COUNT  = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  reg_idx_t              waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  reg_idx_t              raddr_a,
    input  reg_idx_t              raddr_b,
    output logic [DATA_WIDTH-1:0] rdata_a,
    output logic [DATA_WIDTH-1:0] rdata_b
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DATA_WIDTH-1:0] ram_reg [REG_COUNT];
    logic [REG_COUNT-1:0]  valid_reg;
    logic [DATA_WIDTH-1:0] rdata_a_reg;
    logic [DATA_WIDTH-1:0] rdata_b_reg;
    logic                  wr_hit;
    logic                  a_in_range;
    logic                  b_in_range;

    // Register zero and numbers beyond the file take no write
    assign wr_hit     = we && (waddr != '0) && (32'(waddr) < REG_COUNT);
    assign a_in_range = 32'(raddr_a) < REG_COUNT;
    assign b_in_range = 32'(raddr_b) < REG_COUNT;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            ram_reg[waddr[IDX_W-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_hit)
        begin
            valid_reg[waddr[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= (a_in_range && valid_reg[raddr_a[IDX_W-1:0]]) ?
                           ram_reg[raddr_a[IDX_W-1:0]] : '0;
            rdata_b_reg <= (b_in_range && valid_reg[raddr_b[IDX_W-1:0]]) ?
                           ram_reg[raddr_b[IDX_W-1:0]] : '0;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ sv/trmx_alu.sv @@
// Shared arithmetic unit: one adder reused for add, sub, shift-add multiply
// and restoring signed divide. Depends on trmx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trmx_alu
    import trmx_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_req_t              req,
    input  logic [DATA_WIDTH-1:0] opa,
    input  logic [DATA_WIDTH-1:0] opb,
    output alu_rsp_t              rsp,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_ARITH = 3'd1;
    localparam logic [2:0] P_MLOOP = 3'd2;
    localparam logic [2:0] P_NEGA  = 3'd3;
    localparam logic [2:0] P_NEGB  = 3'd4;
    localparam logic [2:0] P_DLOOP = 3'd5;
    localparam logic [2:0] P_DFIX  = 3'd6;
    localparam logic [2:0] P_DONE  = 3'd7;

    logic [2:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  wr_reg, wr_next;
    logic                  neg_reg, neg_next;
    alu_op_t               kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] rx_reg, rx_next;   // accumulator / remainder
    logic [DATA_WIDTH-1:0] ry_reg, ry_next;   // multiplicand / divisor
    logic [DATA_WIDTH-1:0] rq_reg, rq_next;   // multiplier / quotient

    logic [DATA_WIDTH-1:0] add_x;
    logic [DATA_WIDTH-1:0] add_y;
    logic                  add_sub;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] shifted;
    logic                  no_borrow;

    assign shifted = {rx_reg[DATA_WIDTH-2:0], rq_reg[DATA_WIDTH-1]};

    // Operand selection for the one shared adder
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (phase_reg)
            P_ARITH:
            begin
                add_x   = rx_reg;
                add_y   = ry_reg;
                add_sub = (kind_reg == ALU_SUB);
            end
            P_MLOOP:
            begin
                add_x = rx_reg;
                add_y = rq_reg[0] ? ry_reg : '0;
            end
            P_NEGA:
            begin
                add_y   = rx_reg;
                add_sub = 1'b1;
            end
            P_NEGB:
            begin
                add_y   = ry_reg;
                add_sub = 1'b1;
            end
            P_DLOOP:
            begin
                add_x   = shifted;
                add_y   = ry_reg;
                add_sub = 1'b1;
            end
            P_DFIX:
            begin
                add_y   = rq_reg;
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DATA_WIDTH+1){add_sub}})
               + (DATA_WIDTH+1)'(add_sub);
    assign no_borrow = ~sum[DATA_WIDTH];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        wr_next    = wr_reg;
        neg_next   = neg_reg;
        kind_next  = kind_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rq_next    = rq_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    kind_next  = req.op;
                    count_next = '0;
                    wr_next    = 1'b1;
                    case (req.op)
                        ALU_MUL:
                        begin
                            rx_next    = '0;
                            ry_next    = opa;
                            rq_next    = opb;
                            phase_next = P_MLOOP;
                        end
                        ALU_DIV:
                        begin
                            rx_next  = opa;
                            ry_next  = opb;
                            neg_next = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                            if (opb == '0)
                            begin
                                // divide by zero: leave the destination alone
                                wr_next    = 1'b0;
                                phase_next = P_DONE;
                            end
                            else
                            begin
                                phase_next = P_NEGA;
                            end
                        end
                        default:
                        begin
                            rx_next    = opa;
                            ry_next    = opb;
                            phase_next = P_ARITH;
                        end
                    endcase
                end
            end
            P_ARITH:
            begin
                rx_next    = sum[DATA_WIDTH-1:0];
                phase_next = P_DONE;
            end
            P_MLOOP:
            begin
                rx_next    = sum[DATA_WIDTH-1:0];
                ry_next    = {ry_reg[DATA_WIDTH-2:0], 1'b0};
                rq_next    = {1'b0, rq_reg[DATA_WIDTH-1:1]};
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    phase_next = P_DONE;
                end
            end
            P_NEGA:
            begin
                rq_next    = rx_reg[DATA_WIDTH-1] ? sum[DATA_WIDTH-1:0] : rx_reg;
                rx_next    = '0;
                phase_next = P_NEGB;
            end
            P_NEGB:
            begin
                ry_next    = ry_reg[DATA_WIDTH-1] ? sum[DATA_WIDTH-1:0] : ry_reg;
                phase_next = P_DLOOP;
            end
            P_DLOOP:
            begin
                rx_next    = no_borrow ? sum[DATA_WIDTH-1:0] : shifted;
                rq_next    = {rq_reg[DATA_WIDTH-2:0], no_borrow};
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    phase_next = P_DFIX;
                end
            end
            P_DFIX:
            begin
                rx_next    = neg_reg ? sum[DATA_WIDTH-1:0] : rq_reg;
                phase_next = P_DONE;
            end
            P_DONE:
            begin
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            count_reg <= '0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        kind_reg <= kind_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rq_reg   <= rq_next;
    end

    assign rsp.busy     = (phase_reg != P_IDLE);
    assign rsp.done     = (phase_reg == P_DONE);
    assign rsp.write_ok = wr_reg;
    assign result       = rx_reg;

    `ASSERT_IMPLY(a_start_when_idle, clk, rst_n, req.start, phase_reg == P_IDLE,
                  "alu started while busy")
    `ASSERT_NEXT(a_done_single, clk, rst_n, rsp.done, !rsp.done,
                 "alu done held for more than one cycle")
    `ASSERT_NEXT(a_loop_exit, clk, rst_n,
                 (phase_reg == P_DLOOP) && (count_reg == LAST_STEP),
                 phase_reg == P_DFIX, "divide loop did not end after its last step")

endmodule

@@ sv/tiny_register_machine_executor.sv @@
// Top level of the tiny register machine executor: sequencer, register file,
// shared arithmetic unit and print output register. Depends on trmx_pkg,
// trmx_regfile, trmx_alu and assert_macros.svh.
//
//  channel      | handshake                        | payload
//  -------------+----------------------------------+------------------------------
//  instruction  | instruction_valid / _ready       | instruction_word[15:0]
//  result       | result_valid / result_ready      | printed_index[2:0],
//               |                                  | printed_value[31:0] signed
//
// Item flow: each accepted item goes to dispatch, and ready returns only once it
//   is through. Load-immediate and opcodes six and seven end at dispatch; a
//   print then waits on the output register; add, sub, mul and div wait on
//   the shared unit. Mul and div run its one-bit-per-cycle shift loop (a divide
//   by zero skips the loop). Reset clears the sequencer, the output valid flag
//   and the valid bits of the register file, so all registers read zero at once.
//   A print stalls in its own state while an earlier item still waits on the
//   output; the output register lets the next instruction in behind it.
`include "assert_macros.svh"

module tiny_register_machine_executor
    import trmx_pkg::*;
#(
    parameter int REG_COUNT  = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      instruction_valid,
    output logic                      instruction_ready,
    input  logic [INSTR_W-1:0]        instruction_word,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [FIELD_W-1:0]        printed_index,
    output logic signed [PRINT_W-1:0] printed_value
);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // take an item
    localparam logic [1:0] S_DISP  = 2'd1;  // operands are in, dispatch on opcode
    localparam logic [1:0] S_WAIT  = 2'd2;  // wait on the shared unit
    localparam logic [1:0] S_PRINT = 2'd3;  // hold until the output register frees

    logic [1:0]            state_reg, state_next;
    opcode_t               op_reg;
    reg_idx_t              dst_reg;
    logic [IMM_W-1:0]      imm_reg;

    logic                  accept;
    logic                  rf_we;
    logic [DATA_WIDTH-1:0] rf_wdata;
    logic [DATA_WIDTH-1:0] dst_val;
    logic [DATA_WIDTH-1:0] src_val;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic [DATA_WIDTH-1:0] alu_result;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    reg_idx_t              printed_index_reg;
    logic [PRINT_W-1:0]    printed_value_reg;
    logic signed [63:0]    dst_val_ext;

    assign instruction_ready = (state_reg == S_IDLE);
    assign accept            = instruction_valid && instruction_ready;

    // Latch the fields that outlive the acceptance cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= instruction_word[OP_LSB +: FIELD_W];
            dst_reg <= instruction_word[DST_LSB +: FIELD_W];
            imm_reg <= instruction_word[IMM_W-1:0];
        end
    end

    // Operand reads are issued straight from the incoming word, so both
    // values are ready in the dispatch cycle.
    trmx_regfile #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (rf_we),
        .waddr   (dst_reg),
        .wdata   (rf_wdata),
        .re      (accept),
        .raddr_a (instruction_word[DST_LSB +: FIELD_W]),
        .raddr_b (instruction_word[SRC_LSB +: FIELD_W]),
        .rdata_a (dst_val),
        .rdata_b (src_val)
    );

    trmx_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (dst_val),
        .opb    (src_val),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        rf_we         = 1'b0;
        rf_wdata      = alu_result;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (op_reg)
                    OPC_ADD:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_ADD;
                        state_next    = S_WAIT;
                    end
                    OPC_SUB:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_SUB;
                        state_next    = S_WAIT;
                    end
                    OPC_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_MUL;
                        state_next    = S_WAIT;
                    end
                    OPC_DIV:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_DIV;
                        state_next    = S_WAIT;
                    end
                    OPC_LET:
                    begin
                        // immediate is zero-extended
                        rf_we      = 1'b1;
                        rf_wdata   = DATA_WIDTH'(imm_reg);
                        state_next = S_IDLE;
                    end
                    OPC_PRINT:
                    begin
                        state_next = S_PRINT;
                    end
                    default:
                    begin
                        // opcodes six and seven: drop the item
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    rf_we      = alu_rsp.write_ok;
                    state_next = S_IDLE;
                end
            end
            S_PRINT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register: sign-extend the register value, then keep 32 bits
    assign dst_val_ext = 64'($signed(dst_val));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            printed_index_reg <= dst_reg;
            printed_value_reg <= dst_val_ext[PRINT_W-1:0];
        end
    end

    assign result_valid  = out_valid_reg;
    assign printed_index = printed_index_reg;
    assign printed_value = $signed(printed_value_reg);

    `ASSERT_IMPLY(a_ready_unit_idle, clk, rst_n, instruction_ready, !alu_rsp.busy,
                  "instruction taken while the arithmetic unit is busy")
    `ASSERT_IMPLY(a_done_in_wait, clk, rst_n, alu_rsp.done, state_reg == S_WAIT,
                  "arithmetic unit finished outside the wait state")
    `ASSERT_IMPLY(a_write_states, clk, rst_n, rf_we,
                  (state_reg == S_DISP) || (state_reg == S_WAIT),
                  "register file written outside dispatch or wait")
    `ASSERT_NEXT(a_accept_dispatch, clk, rst_n, accept, state_reg == S_DISP,
                 "accepted item not dispatched in the next cycle")

endmodule

@@ tb/tiny_register_machine_executor_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tiny_register_machine_executor: directed table, then random
// instruction streams with random stalls, checked by a register-file predictor.
// Depends on trmx_pkg and the RTL of the block.
module tiny_register_machine_executor_test;
    import trmx_pkg::*;

    localparam int REG_COUNT    = 8;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1675;
    localparam int CALM_TAIL    = 200;    // last random items sent with no idling
    localparam int HOLD_AT_ITEM = 300;    // random item at which the long hold-off starts
    localparam int LONG_HOLD    = 400;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = DATA_WIDTH + 16;

    // Opcodes six and seven have no name in the package; both do nothing.
    localparam opcode_t OPC_NOP6 = 3'd6;
    localparam opcode_t OPC_NOP7 = 3'd7;

    typedef struct packed {
        reg_idx_t                index;
        logic signed [PRINT_W-1:0] value;
    } print_result_t;

    typedef struct packed {
        logic [INSTR_W-1:0] word;
        logic               typed_in;   // expected print given in the row itself
        print_result_t      typed_print;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       instruction_valid;
    logic                       instruction_ready;
    logic [INSTR_W-1:0]         instruction_word;
    logic                       result_valid;
    logic                       result_ready;
    logic [FIELD_W-1:0]         printed_index;
    logic signed [PRINT_W-1:0]  printed_value;

    // Predictor state: a shadow of the register file, all zero after reset.
    logic [DATA_WIDTH-1:0] reg_shadow [REG_COUNT];
    print_result_t         pending_prints [$];
    stim_row_t             directed_rows [$];
    print_result_t         oldest_print;
    int                    mismatches = 0;
    bit                    calm = 1'b0;           // no idling on either side
    bit                    long_hold_pending = 1'b0;

    tiny_register_machine_executor #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .instruction_valid (instruction_valid),
        .instruction_ready (instruction_ready),
        .instruction_word  (instruction_word),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .printed_index     (printed_index),
        .printed_value     (printed_value)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [INSTR_W-1:0] make_word(input opcode_t op, input reg_idx_t dst,
                                                     input reg_idx_t src,
                                                     input logic [IMM_W-1:0] imm);
        return {op, dst, src, imm};
    endfunction

    // Execute one instruction on the shadow registers; return 1 when it prints.
    function automatic logic execute_on_shadow(input logic [INSTR_W-1:0] w,
                                               output print_result_t outcome);
        opcode_t               op;
        reg_idx_t              dst;
        reg_idx_t              src;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] wb;
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [DATA_WIDTH-1:0] quot;
        logic                  do_write;
        op  = w[OP_LSB +: FIELD_W];
        dst = w[DST_LSB +: FIELD_W];
        src = w[SRC_LSB +: FIELD_W];
        a   = reg_shadow[dst];
        b   = reg_shadow[src];
        wb  = '0;
        do_write = 1'b1;
        outcome.index = dst;
        outcome.value = a;
        case (op)
            OPC_ADD: wb = a + b;
            OPC_SUB: wb = a - b;
            OPC_MUL: wb = a * b;
            OPC_DIV:
            begin
                // Divide by zero keeps the destination; min / -1 wraps back to min.
                if (b == '0)
                    do_write = 1'b0;
                else
                begin
                    mag_a = a[DATA_WIDTH-1] ? -a : a;
                    mag_b = b[DATA_WIDTH-1] ? -b : b;
                    quot  = mag_a / mag_b;
                    wb    = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quot : quot;
                end
            end
            OPC_LET: wb = DATA_WIDTH'(w[IMM_W-1:0]);
            default: do_write = 1'b0;   // print and the two idle opcodes
        endcase
        if (do_write && dst != '0)
            reg_shadow[dst] = wb;
        return op == OPC_PRINT;
    endfunction

    task automatic add_row(input logic [INSTR_W-1:0] w, input logic typed_in,
                           input reg_idx_t idx, input logic [PRINT_W-1:0] val);
        stim_row_t row;
        row.word              = w;
        row.typed_in          = typed_in;
        row.typed_print.index = idx;
        row.typed_print.value = val;
        directed_rows.push_back(row);
    endtask

    // Offer one item and hold it until accepted, then record what it should print.
    task automatic offer_item(input logic [INSTR_W-1:0] w, input logic typed_in,
                              input print_result_t typed_print);
        print_result_t predicted;
        logic          prints;
        @(negedge clk);
        instruction_valid <= 1'b1;
        instruction_word  <= w;
        @(posedge clk);
        while (!instruction_ready)
            @(posedge clk);
        prints = execute_on_shadow(w, predicted);
        if (typed_in)
            pending_prints.push_back(typed_print);
        else if (prints)
            pending_prints.push_back(predicted);
    endtask

    // Drop valid for a burst of cycles, scrambling the idle bus.
    task automatic sender_gap(input int cycles);
        @(negedge clk);
        instruction_valid <= 1'b0;
        instruction_word  <= INSTR_W'($urandom);
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic send_item(input logic [INSTR_W-1:0] w, input logic typed_in,
                             input print_result_t typed_print);
        if (!calm && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 15));
        offer_item(w, typed_in, typed_print);
    endtask

    // Mostly well-formed instructions with loads and prints mixed in so that
    // registers carry values; a few raw words exercise arbitrary bit patterns.
    function automatic logic [INSTR_W-1:0] random_instruction();
        int      pick;
        opcode_t op;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return INSTR_W'($urandom);
        else if (pick < 25)
            op = OPC_LET;
        else if (pick < 47)
            op = OPC_PRINT;
        else if (pick < 59)
            op = OPC_ADD;
        else if (pick < 71)
            op = OPC_SUB;
        else if (pick < 83)
            op = OPC_MUL;
        else if (pick < 95)
            op = OPC_DIV;
        else
            op = (pick < 97) ? OPC_NOP6 : OPC_NOP7;
        return make_word(op, reg_idx_t'($urandom_range(0, 7)), reg_idx_t'($urandom_range(0, 7)),
                         IMM_W'($urandom));
    endfunction

    // Receiver: random ready bursts, one long hold-off on request, always ready when calm.
    initial
    begin
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                // Hold off long enough that the output register and the
                // sequencer fill, which must stall the instruction side.
                result_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(negedge clk);
                long_hold_pending = 1'b0;
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 20))
                    @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(negedge clk);
            end
        end
    end

    // Compare each accepted print with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_prints.size() == 0)
            begin
                $display("%0t: unexpected print: expected none, got index %0d value %0d",
                         $time, printed_index, printed_value);
                mismatches++;
            end
            else
            begin
                oldest_print = pending_prints.pop_front();
                if (printed_index !== oldest_print.index)
                begin
                    $display("%0t: printed_index mismatch: expected %0d, got %0d",
                             $time, oldest_print.index, printed_index);
                    mismatches++;
                end
                if (printed_value !== oldest_print.value)
                begin
                    $display("%0t: printed_value mismatch: expected %0d, got %0d",
                             $time, oldest_print.value, printed_value);
                    mismatches++;
                end
            end
        end
    end

    // Run limit: far above the slowest legal run (every item a full divide plus
    // the longest gaps on both sides, and the long hold-off).
    initial
    begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        print_result_t no_print;
        int            n;
        no_print = '0;
        rst_n             = 1'b0;
        instruction_valid = 1'b0;
        instruction_word  = '0;
        for (n = 0; n < REG_COUNT; n++)
            reg_shadow[n] = '0;

        // Directed table. Rows with a typed-in print can be read off directly;
        // the rest go through the predictor.
        add_row(make_word(OPC_PRINT, 3'd0, 3'd0, 7'd0),   1'b1, 3'd0, 32'd0);  // after reset
        add_row(make_word(OPC_PRINT, 3'd7, 3'd0, 7'd0),   1'b1, 3'd7, 32'd0);
        add_row(make_word(OPC_LET,   3'd1, 3'd0, 7'h7F),  1'b0, 3'd0, 32'd0);  // largest imm
        add_row(make_word(OPC_PRINT, 3'd1, 3'd0, 7'd0),   1'b1, 3'd1, 32'd127);
        add_row(make_word(OPC_LET,   3'd0, 3'd7, 7'd5),   1'b0, 3'd0, 32'd0);  // write to r0
        add_row(make_word(OPC_PRINT, 3'd0, 3'd0, 7'd0),   1'b1, 3'd0, 32'd0);
        add_row(make_word(OPC_LET,   3'd2, 3'd0, 7'd64),  1'b0, 3'd0, 32'd0);
        add_row(make_word(OPC_MUL,   3'd2, 3'd2, 7'd0),   1'b0, 3'd0, 32'd0);
        add_row(make_word(OPC_MUL,   3'd2, 3'd2, 7'd0),   1'b0, 3'd0, 32'd0);  // 2^24
        add_row(make_word(OPC_LET,   3'd4, 3'd0, 7'd64),  1'b0, 3'd0, 32'd0);
        add_row(make_word(OPC_ADD,   3'd4, 3'd4, 7'd0),   1'b0, 3'd0, 32'd0);  // 128
        add_row(make_word(OPC_MUL,   3'd2, 3'd4, 7'd0),   1'b0, 3'd0, 32'd0);  // most negative
        add_row(make_word(OPC_LET,   3'd6, 3'd0, 7'd1),   1'b0, 3'd0, 32'd0);
        add_row(make_word(OPC_SUB,   3'd5, 3'd6, 7'd0),   1'b0, 3'd0, 32'd0);  // -1
        add_row(make_word(OPC_PRINT, 3'd5, 3'd0, 7'd0),   1'b1, 3'd5, 32'hFFFF_FFFF);
        add_row(make_word(OPC_DIV,   3'd2, 3'd5, 7'd0),   1'b0, 3'd0, 32'd0);  // min / -1
        add_row(make_word(OPC_PRINT, 3'd2, 3'd0, 7'd0),   1'b1, 3'd2, 32'h8000_0000);
        add_row(make_word(OPC_DIV,   3'd1, 3'd7, 7'd0),   1'b0, 3'd0, 32'd0);  // divide by zero
        add_row(make_word(OPC_PRINT, 3'd1, 3'd0, 7'd0),   1'b1, 3'd1, 32'd127);
        add_row(16'hFFFF,                                 1'b0, 3'd0, 32'd0);  // opcode seven
        add_row(16'hDFFF,                                 1'b0, 3'd0, 32'd0);  // opcode six
        add_row(make_word(OPC_PRINT, 3'd7, 3'd0, 7'd0),   1'b1, 3'd7, 32'd0);
        add_row(make_word(OPC_DIV,   3'd1, 3'd5, 7'd0),   1'b0, 3'd0, 32'd0);  // 127 / -1
        add_row(make_word(OPC_MUL,   3'd2, 3'd2, 7'd0),   1'b0, 3'd0, 32'd0);  // wraps to 0
        add_row(make_word(OPC_PRINT, 3'd1, 3'd0, 7'd0),   1'b0, 3'd0, 32'd0);

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].word, directed_rows[i].typed_in,
                      directed_rows[i].typed_print);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT_ITEM)
                long_hold_pending = 1'b1;
            if (n == RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            send_item(random_instruction(), 1'b0, no_print);
        end

        // Release the bus, drain every expected print, then let a worst-case
        // divide run out before deciding.
        @(negedge clk);
        instruction_valid <= 1'b0;
        while (pending_prints.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
